// ===== sv/jdcs_pkg.sv =====
`timescale 1ns / 1ps

package jdcs_pkg;

  localparam int MAX_ITER = 100;

  localparam int IN_W      = 32;
  localparam int OUT_W     = 40;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PINCHOFF  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VTO_TC    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_TC   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd7;

  localparam logic [6:0] PASSES_MAX = 7'd127;

endpackage

// ===== sv/jfet_drain_current_solver.sv =====
`timescale 1ns / 1ps

// Square-law JFET drain current solver. Each input word carries the gate and the drain
// voltage in mV; the block applies temperature correction to threshold and gain, then
// repeats I = f(Vgs, Vd - I*Rs) from zero until the change is within tolerance or the pass
// limit is hit, and returns the current in nA with the passes used and a converged flag.
// One word is in flight at a time: s_tready is low from acceptance until the result has
// been moved to the output register. Apart from the mV-to-uV scaling, all products come
// from one shared 32x32 multiplier that builds each wide product from four partial
// products; a division by 1000 or 10^6 is a reciprocal multiply, a back-multiply and
// one correction step. A pass in cutoff skips the current products, and the result
// waits for the output register while the previous result is still held there.
module jfet_drain_current_solver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [jdcs_pkg::IN_W-1:0]          s_tdata,   // gate_voltage_mv, drain_voltage_mv
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [jdcs_pkg::OUT_W-1:0]         m_tdata,   // drain_current_na, passes_used, converged
  input  logic                               cfg_we,
  input  logic [jdcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jdcs_pkg::CFG_W-1:0]         cfg_data
);
  import jdcs_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE     = 21'h000001,
    ST_MUL      = 21'h000002,
    ST_DIV      = 21'h000004,
    ST_VTO_DIV  = 21'h000008,
    ST_VTO_END  = 21'h000010,
    ST_G_DIV    = 21'h000020,
    ST_G_END    = 21'h000040,
    ST_BC_END   = 21'h000080,
    ST_LOOP     = 21'h000100,
    ST_DROP_DIV = 21'h000200,
    ST_DROP_END = 21'h000400,
    ST_Q_END    = 21'h000800,
    ST_L_DIV    = 21'h001000,
    ST_L_END    = 21'h002000,
    ST_A1_END   = 21'h004000,
    ST_A2_END   = 21'h008000,
    ST_A_END    = 21'h010000,
    ST_CHECK    = 21'h020000,
    ST_DONE     = 21'h040000,
    ST_DIV_Q    = 21'h080000,
    ST_DIV_FIX  = 21'h100000
  } state_t;

  localparam logic [19:0] DIV_1E3 = 20'd1000;
  localparam logic [19:0] DIV_1E6 = 20'd1000000;
  localparam logic [63:0] RECIP_1E3 = 64'd9444732965739290427;
  localparam logic [63:0] RECIP_1E6 = 64'd9671406556917033397;
  localparam logic signed [45:0] VDS_HI = 46'sd2147483648;
  localparam logic signed [45:0] VDS_LO = -46'sd2147483648;

  state_t state, ret, div_ret;

  logic [31:0]        beta_scaled, lambda_scaled, series_res_mohm;
  logic signed [15:0] pinchoff_mv;
  logic signed [18:0] temp_offset_mk;
  logic signed [17:0] vto_tempco;
  logic signed [23:0] beta_tempco;
  logic [19:0]        tolerance_na;

  logic signed [27:0] vgs_uv, vd_uv, vov;
  logic [34:0]        beta_c;
  logic signed [31:0] cur, prev;
  logic signed [32:0] vds;
  logic [62:0]        q_mag;
  logic               q_neg, m_neg, sgn_neg, conv;
  logic [44:0]        m_mag;
  logic [7:0]         iter;

  logic [63:0]  mul_a, mul_b, prod;
  logic [2:0]   mul_step;
  logic [1:0]   prod_sh;
  logic [127:0] acc;

  logic [63:0] div_num;
  logic [19:0] div_d;

  logic [31:0]        a_part, b_part;
  logic [127:0]       acc_add;
  logic [63:0]        sat_acc;
  logic [63:0]        div_est, div_rem, div_q;
  logic signed [27:0] gate_uv, drain_uv, pinch_uv, vto_q;
  logic signed [34:0] g_q, g_sum;
  logic [26:0]        g_clamp;
  logic signed [45:0] drop_s, vsum, m_q, m_sum;
  logic signed [32:0] vds_calc;
  logic signed [34:0] t_val;
  logic [31:0]        cur_mag, vds_mag;
  logic signed [31:0] cur_calc;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [7:0]         iter_next;
  logic               conv_calc;

  always_comb begin
    a_part    = mul_step[0] ? mul_a[63:32] : mul_a[31:0];
    b_part    = mul_step[1] ? mul_b[63:32] : mul_b[31:0];
    acc_add   = acc + ({64'd0, prod} << {prod_sh, 5'd0});
    sat_acc   = (|acc[127:96]) ? '1 : acc[95:32];
    div_est   = (div_d == DIV_1E3) ? {9'd0, acc[127:73]} : {19'd0, acc[127:83]};
    div_rem   = div_num - acc[63:0];
    div_q     = mul_a + 64'(div_rem >= 64'(div_d));

    gate_uv  = 28'(signed'(s_tdata[15:0])) * 28'sd1000;
    drain_uv = 28'(signed'(s_tdata[31:16])) * 28'sd1000;
    pinch_uv = 28'(pinchoff_mv) * 28'sd1000;
    vto_q    = $signed({1'b0, div_num[26:0]});
    if (sgn_neg) vto_q = -vto_q;

    g_q   = $signed({3'b0, div_num[31:0]});
    g_sum = 35'sd16777216 + (sgn_neg ? -g_q : g_q);
    if (g_sum < 0) begin
      g_clamp = '0;
    end else if (g_sum > 35'sd67108864) begin
      g_clamp = 27'd67108864;
    end else begin
      g_clamp = g_sum[26:0];
    end

    drop_s = $signed({2'b0, div_num[43:0]});
    vsum   = cur[31] ? 46'(vd_uv) + drop_s : 46'(vd_uv) - drop_s;
    if (vsum > VDS_HI) begin
      vds_calc = 33'(VDS_HI);
    end else if (vsum < VDS_LO) begin
      vds_calc = 33'(VDS_LO);
    end else begin
      vds_calc = vsum[32:0];
    end
    t_val   = 35'(vov) + 35'(vov) - 35'(vds_calc);
    vds_mag = vds_calc[32] ? 32'(-vds_calc) : 32'(vds_calc);

    m_q   = $signed({2'b0, div_num[43:0]});
    m_sum = 46'sd4294967296 + (sgn_neg ? -m_q : m_q);

    cur_mag = cur[31] ? 32'(-cur) : 32'(cur);
    if (q_neg ^ m_neg) begin
      cur_calc = (div_num >= 64'd2147483648) ? 32'sh80000000 : -$signed(div_num[31:0]);
    end else begin
      cur_calc = (div_num > 64'd2147483647) ? 32'sh7fffffff : $signed(div_num[31:0]);
    end

    diff      = 33'(cur) - 33'(prev);
    diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
    conv_calc = diff_mag <= {13'd0, tolerance_na};
    iter_next = iter + 8'd1;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_scaled     <= 32'd5600637;
      pinchoff_mv     <= -16'sd3000;
      lambda_scaled   <= 32'd9663676;
      series_res_mohm <= 32'd2000;
      temp_offset_mk  <= '0;
      vto_tempco      <= -18'sd2500;
      beta_tempco     <= -24'sd83886;
      tolerance_na    <= 20'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BETA:      beta_scaled     <= cfg_data;
        CFG_PINCHOFF:  pinchoff_mv     <= cfg_data[15:0];
        CFG_LAMBDA:    lambda_scaled   <= cfg_data;
        CFG_SERIES:    series_res_mohm <= cfg_data;
        CFG_TEMP:      temp_offset_mk  <= cfg_data[18:0];
        CFG_VTO_TC:    vto_tempco      <= cfg_data[17:0];
        CFG_BETA_TC:   beta_tempco     <= cfg_data[23:0];
        CFG_TOLERANCE: tolerance_na    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      div_ret  <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            vgs_uv   <= gate_uv;
            vd_uv    <= drain_uv;
            mul_a    <= 64'($unsigned(vto_tempco[17] ? -vto_tempco : vto_tempco));
            mul_b    <= 64'($unsigned(temp_offset_mk[18] ? -temp_offset_mk : temp_offset_mk));
            sgn_neg  <= vto_tempco[17] ^ temp_offset_mk[18];
            acc      <= '0;
            mul_step <= '0;
            ret      <= ST_VTO_DIV;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_step != 3'd4) begin
            prod    <= 64'(a_part) * 64'(b_part);
            prod_sh <= 2'(mul_step[0]) + 2'(mul_step[1]);
          end
          if (mul_step != 3'd0) acc <= acc_add;
          mul_step <= mul_step + 3'd1;
          if (mul_step == 3'd4) state <= ret;
        end
        ST_DIV: begin
          mul_a    <= div_num;
          mul_b    <= (div_d == DIV_1E3) ? RECIP_1E3 : RECIP_1E6;
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_DIV_Q;
          state    <= ST_MUL;
        end
        ST_DIV_Q: begin
          mul_a    <= div_est;
          mul_b    <= 64'(div_d);
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_DIV_FIX;
          state    <= ST_MUL;
        end
        ST_DIV_FIX: begin
          div_num <= div_q;
          state   <= div_ret;
        end
        ST_VTO_DIV: begin
          div_num <= acc[63:0];
          div_d   <= DIV_1E3;
          div_ret <= ST_VTO_END;
          state   <= ST_DIV;
        end
        ST_VTO_END: begin
          vov      <= vgs_uv - (pinch_uv + vto_q);
          mul_a    <= 64'($unsigned(beta_tempco[23] ? -beta_tempco : beta_tempco));
          mul_b    <= 64'($unsigned(temp_offset_mk[18] ? -temp_offset_mk : temp_offset_mk));
          sgn_neg  <= beta_tempco[23] ^ temp_offset_mk[18];
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_G_DIV;
          state    <= ST_MUL;
        end
        ST_G_DIV: begin
          div_num <= acc[63:0];
          div_d   <= DIV_1E3;
          div_ret <= ST_G_END;
          state   <= ST_DIV;
        end
        ST_G_END: begin
          mul_a    <= 64'(beta_scaled);
          mul_b    <= 64'(g_clamp);
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_BC_END;
          state    <= ST_MUL;
        end
        ST_BC_END: begin
          beta_c <= acc[58:24];
          cur    <= '0;
          iter   <= '0;
          state  <= ST_LOOP;
        end
        ST_LOOP: begin
          prev     <= cur;
          mul_a    <= 64'(cur_mag);
          mul_b    <= 64'(series_res_mohm);
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_DROP_DIV;
          state    <= ST_MUL;
        end
        ST_DROP_DIV: begin
          div_num <= acc[63:0];
          div_d   <= DIV_1E6;
          div_ret <= ST_DROP_END;
          state   <= ST_DIV;
        end
        ST_DROP_END: begin
          vds <= vds_calc;
          if (vov <= 0) begin
            cur   <= '0;
            state <= ST_CHECK;
          end else begin
            if (34'(vds_calc) >= 34'(vov)) begin
              mul_a <= 64'(vov[26:0]);
              mul_b <= 64'(vov[26:0]);
              q_neg <= 1'b0;
            end else begin
              mul_a <= 64'(vds_mag);
              mul_b <= 64'(t_val[31:0]);
              q_neg <= vds_calc[32];
            end
            acc      <= '0;
            mul_step <= '0;
            ret      <= ST_Q_END;
            state    <= ST_MUL;
          end
        end
        ST_Q_END: begin
          q_mag    <= acc[62:0];
          mul_a    <= 64'(lambda_scaled);
          mul_b    <= 64'($unsigned(vds[32] ? 32'(-vds) : 32'(vds)));
          sgn_neg  <= vds[32];
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_L_DIV;
          state    <= ST_MUL;
        end
        ST_L_DIV: begin
          div_num <= acc[63:0];
          div_d   <= DIV_1E6;
          div_ret <= ST_L_END;
          state   <= ST_DIV;
        end
        ST_L_END: begin
          m_neg    <= m_sum[45];
          m_mag    <= m_sum[45] ? 45'(-m_sum) : 45'(m_sum);
          mul_a    <= 64'(beta_c);
          mul_b    <= 64'(q_mag);
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_A1_END;
          state    <= ST_MUL;
        end
        ST_A1_END: begin
          mul_a    <= sat_acc;
          mul_b    <= 64'(m_mag);
          acc      <= '0;
          mul_step <= '0;
          ret      <= ST_A2_END;
          state    <= ST_MUL;
        end
        ST_A2_END: begin
          div_num <= sat_acc;
          div_d   <= DIV_1E3;
          div_ret <= ST_A_END;
          state   <= ST_DIV;
        end
        ST_A_END: begin
          cur   <= cur_calc;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          iter <= iter_next;
          conv <= conv_calc;
          if (conv_calc || iter_next == 8'(MAX_ITER)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_LOOP;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {conv, (iter > 8'(PASSES_MAX)) ? PASSES_MAX : iter[6:0], cur};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/jdcs_chk.sv =====
`timescale 1ns / 1ps

module jdcs_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [jdcs_pkg::OUT_W-1:0]   m_tdata
);
  import jdcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while solving");

  a_passes_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] != 7'd0 && m_tdata[38:32] <= 7'(MAX_ITER))
    else $error("pass count out of range");

  a_limit_when_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[39] |-> m_tdata[38:32] == 7'(MAX_ITER))
    else $error("not converged before pass limit");

endmodule

bind jfet_drain_current_solver jdcs_chk u_jdcs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/jfet_current_checker.sv =====
`timescale 1ns / 1ps

module jfet_current_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [jdcs_pkg::IN_W-1:0]      s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [jdcs_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_we,
  input  logic [jdcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jdcs_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             solved
);
  import jdcs_pkg::*;

  typedef struct packed {
    logic       conv;
    logic [6:0] passes;
    logic [31:0] current;
  } solution_t;

  localparam longint unsigned ONE_MILLION = 64'd1000000;

  logic [31:0]        beta_gain, lambda_clm, series_res;
  logic [19:0]        tol_na;
  logic signed [15:0] pinch_mv;
  logic signed [18:0] temp_mk;
  logic signed [17:0] vto_tc;
  logic signed [23:0] beta_tc;

  solution_t expected_solutions[$];

  function automatic longint unsigned mul_hi_sat(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> 32;
    if (p[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return p[63:0];
  endfunction

  function automatic longint solve_point(longint vov, longint vds, longint unsigned bc);
    longint q, m;
    longint unsigned qa, ma, a;
    bit neg;
    if (vov <= 0) return 0;
    if (vds >= vov) q = vov * vov;
    else q = vds * (2 * vov - vds);
    m = (64'sd1 <<< 32) + (longint'(lambda_clm) * vds) / 64'sd1000000;
    qa = (q < 0) ? longint'(-q) : longint'(q);
    ma = (m < 0) ? longint'(-m) : longint'(m);
    a = mul_hi_sat(bc, qa);
    a = mul_hi_sat(a, ma);
    a = a / 64'd1000;
    neg = (q < 0) != (m < 0);
    if (neg) return (a >= 64'd2147483648) ? -64'sd2147483648 : -longint'(a);
    return (a > 64'd2147483647) ? 64'sd2147483647 : longint'(a);
  endfunction

  function automatic solution_t solve_current(logic [15:0] gate, logic [15:0] drain);
    longint vgs, vd, vto, g, vov, cur, prev, diff, vds, drop;
    longint unsigned bc, cmag;
    int n;
    bit conv;
    solution_t r;
    vgs = longint'($signed(gate)) * 1000;
    vd = longint'($signed(drain)) * 1000;
    vto = longint'(pinch_mv) * 1000 + (longint'(vto_tc) * longint'(temp_mk)) / 64'sd1000;
    g = (64'sd1 <<< 24) + (longint'(beta_tc) * longint'(temp_mk)) / 64'sd1000;
    if (g < 0) g = 0;
    if (g > (64'sd1 <<< 26)) g = 64'sd1 <<< 26;
    bc = (longint'(beta_gain) * g) >> 24;
    vov = vgs - vto;
    cur = 0;
    n = 0;
    do begin
      prev = cur;
      cmag = (cur < 0) ? longint'(-cur) : longint'(cur);
      drop = longint'((cmag * longint'(series_res)) / ONE_MILLION);
      vds = (cur < 0) ? vd + drop : vd - drop;
      if (vds > 64'sd2147483648) vds = 64'sd2147483648;
      if (vds < -64'sd2147483648) vds = -64'sd2147483648;
      cur = solve_point(vov, vds, bc);
      n++;
      diff = cur - prev;
      conv = ((diff < 0) ? -diff : diff) <= longint'(tol_na);
    end while (!conv && n < MAX_ITER);
    r.current = cur[31:0];
    r.passes = (n > 127) ? PASSES_MAX : n[6:0];
    r.conv = conv;
    return r;
  endfunction

  assign outstanding = expected_solutions.size();

  always @(posedge clk) begin
    if (rst) begin
      beta_gain <= 32'd5600637;
      pinch_mv <= -16'sd3000;
      lambda_clm <= 32'd9663676;
      series_res <= 32'd2000;
      temp_mk <= '0;
      vto_tc <= -18'sd2500;
      beta_tc <= -24'sd83886;
      tol_na <= 20'd1000;
      errors <= 0;
      solved <= 0;
      expected_solutions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BETA:      beta_gain <= cfg_data;
          CFG_PINCHOFF:  pinch_mv <= cfg_data[15:0];
          CFG_LAMBDA:    lambda_clm <= cfg_data;
          CFG_SERIES:    series_res <= cfg_data;
          CFG_TEMP:      temp_mk <= cfg_data[18:0];
          CFG_VTO_TC:    vto_tc <= cfg_data[17:0];
          CFG_BETA_TC:   beta_tc <= cfg_data[23:0];
          CFG_TOLERANCE: tol_na <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_solutions.push_back(solve_current(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        solved <= solved + 1;
        if (expected_solutions.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected word %h", m_tdata);
        end else begin
          solution_t e;
          e = expected_solutions.pop_front();
          if (m_tdata[31:0] !== e.current || m_tdata[38:32] !== e.passes ||
              m_tdata[39] !== e.conv) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: current %0d/%0d passes %0d/%0d conv %0d/%0d (exp/act)",
                       $signed(e.current), $signed(m_tdata[31:0]), e.passes,
                       m_tdata[38:32], e.conv, m_tdata[39]);
          end
        end
      end
    end
  end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import jdcs_pkg::*;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors, outstanding, solved;
  int                   burst_left = 0;
  int                   sent = 0;
  bit                   hold_req = 0;

  always #5 clk = ~clk;

  jfet_drain_current_solver DUT (.*);

  jfet_current_checker checker_i (.*);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic send_word(logic [15:0] gate, logic [15:0] drain);
    int gap;
    s_tvalid <= 1;
    s_tdata <= {drain, gate};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic tame_config();
    write_reg(CFG_BETA, $urandom_range(1000000, 20000000));
    write_reg(CFG_PINCHOFF, 32'(-$urandom_range(500, 6000)));
    write_reg(CFG_LAMBDA, $urandom_range(0, 50000000));
    write_reg(CFG_SERIES, $urandom_range(0, 5000));
    write_reg(CFG_TEMP, 32'($urandom_range(0, 100000)) - 32'd50000);
    write_reg(CFG_VTO_TC, 32'($urandom_range(0, 10000)) - 32'd5000);
    write_reg(CFG_BETA_TC, 32'($urandom_range(0, 200000)) - 32'd100000);
    write_reg(CFG_TOLERANCE, $urandom_range(100, 100000));
  endtask

  task automatic random_word();
    logic [15:0] g, d;
    g = 16'($urandom);
    d = 16'($urandom);
    if ($urandom_range(0, 6) != 0) begin
      g = 16'($urandom_range(0, 8000)) - 16'd6000;
      d = 16'($urandom_range(0, 24000)) - 16'd4000;
    end
    send_word(g, d);
  endtask

  // receiver: random ready patterns, plus one long hold-off on request
  initial begin
    int mode, span;
    forever begin
      if (hold_req) begin
        m_tready <= 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 400);
        repeat (span) begin
          case (mode)
            0: m_tready <= 1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset defaults: field extremes, cutoff, linear and saturation regions
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'd0, 16'd0);
    send_word(16'd0, 16'd10000);
    send_word(16'd0, 16'd500);
    send_word(-16'sd1000, 16'd200);
    send_word(-16'sd3000, 16'd5000);
    send_word(-16'sd2999, 16'd5000);
    send_word(16'd0, -16'sd2000);
    send_word(16'hFFFF, 16'hFFFF);
    wait_idle();

    // gain clamped to zero, then to the upper limit; ignored indexes
    write_reg(CFG_TEMP, 32'h0003_0D40);
    write_reg(CFG_BETA_TC, 32'h0080_0000);
    write_reg(4'd8, 32'hFFFF_FFFF);
    write_reg(4'd15, 32'h1234_5678);
    send_word(16'd2000, 16'd5000);
    send_word(16'd0, 16'd200);
    wait_idle();
    write_reg(CFG_BETA_TC, 32'hFF7F_FFFF);
    write_reg(CFG_VTO_TC, 32'hFFFE_79E0);
    write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
    send_word(16'd0, 16'd5000);
    send_word(16'h7FFF, 16'h7FFF);
    wait_idle();

    // extremes: huge gain, huge drop, zero tolerance, max pinch-off
    write_reg(CFG_TEMP, 32'hFFFC_F2C0);
    write_reg(CFG_VTO_TC, 32'h0001_86A0);
    write_reg(CFG_BETA, 32'hFFFF_FFFF);
    write_reg(CFG_LAMBDA, 32'hFFFF_FFFF);
    write_reg(CFG_SERIES, 32'hFFFF_FFFF);
    write_reg(CFG_TOLERANCE, 32'd0);
    write_reg(CFG_PINCHOFF, 32'h0000_8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    wait_idle();
    write_reg(CFG_PINCHOFF, 32'hABCD_7FFF);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h7FFF);
    wait_idle();

    // long receiver hold-off while words keep coming
    tame_config();
    hold_req = 1;
    repeat (8) random_word();
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 4 == 3) begin
        for (int r = 0; r < 8; r++) write_reg(r[CFG_IDX_W-1:0], $urandom);
        repeat (6) random_word();
      end else begin
        tame_config();
        repeat (135) random_word();
      end
      wait_idle();
    end

    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d words, checked %0d results across reset, directed and 12 random setups",
             sent, solved);
    $display("covered cutoff, clamped gain, saturated drop and current, long output stall");
    if (errors == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
